FILE: sv/afd_pkg.sv
// Shared types, constants and tables for the 2D affine TRS decomposition pipeline.
package afd_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int CORDIC_STAGES = 18;

    localparam int QM_W      = FRAC_BITS + 1;
    localparam int VW        = 44;
    localparam int ZW        = 36;
    localparam int VEC_SHIFT = 40 - FRAC_BITS;
    localparam int RAD_SH    = 30 - FRAC_BITS;
    localparam int DEG_SH    = 56 - FRAC_BITS;

    localparam int SQ_CELLS  = 32;
    localparam int DIV_CELLS = FRAC_BITS + 1;
    localparam int COR_CELLS = CORDIC_STAGES;

    localparam int ST_SUM     = 2;
    localparam int ST_SQ_END  = ST_SUM + SQ_CELLS;
    localparam int ST_DIV_END = ST_SQ_END + DIV_CELLS;
    localparam int ST_QM      = ST_DIV_END + 1;
    localparam int ST_SIN_END = ST_QM + SQ_CELLS;
    localparam int ST_COR_END = ST_SIN_END + COR_CELLS;
    localparam int ST_ANG     = ST_COR_END + 1;
    localparam int ST_OUT     = ST_ANG + 1;

    localparam logic [QM_W-1:0] ONE_Q   = QM_W'(1) << FRAC_BITS;
    localparam logic [63:0]     ONE_SQ  = 64'(1) << (2 * FRAC_BITS);
    localparam logic [ZW-1:0]   PI_HALF = ZW'(64'd1686629713);
    localparam logic [ZW-1:0]   PI_Z    = ZW'(64'd3373259426);
    localparam logic [31:0]     DEG_K   = 32'd3845054675;
    localparam logic [64:0]     ROT_MAX = 65'h0FFFFFF;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
    } in_t;

    typedef struct packed {
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic [31:0]        scale_x;
        logic [31:0]        scale_y;
        logic [23:0]        rotation;
        logic               scale_x_zero;
    } out_t;

    typedef struct packed {
        logic [63:0] n;
        logic [63:0] res;
    } sqrt_t;

    typedef struct packed {
        logic [31:0]     r;
        logic [QM_W-1:0] q;
        logic [31:0]     d;
    } div_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic [31:0]        a_mag;
        logic               a_neg;
        logic [31:0]        sx;
        logic [31:0]        sy;
        logic [QM_W-1:0]    qm;
    } side_t;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] u;
        u = v;
        return v[31] ? (32'd0 - u) : u;
    endfunction

    function automatic logic [29:0] atan_q30(input logic [4:0] k);
        logic [29:0] a;
        unique case (k)
            5'd0:  a = 30'd843314857;
            5'd1:  a = 30'd497837829;
            5'd2:  a = 30'd263043837;
            5'd3:  a = 30'd133525159;
            5'd4:  a = 30'd67021687;
            5'd5:  a = 30'd33543516;
            5'd6:  a = 30'd16775851;
            5'd7:  a = 30'd8388437;
            5'd8:  a = 30'd4194283;
            5'd9:  a = 30'd2097149;
            5'd31: a = 30'd0;
            default: a = 30'(64'd1 << (5'd30 - k));
        endcase
        return a;
    endfunction

endpackage

FILE: sv/afd_sqrt_cell.sv
// One bit step of the digit-by-digit integer square root chain.
module afd_sqrt_cell (
    input  logic            aclk,
    input  logic            en,
    input  logic [4:0]      step,
    input  afd_pkg::sqrt_t  d_in,
    output afd_pkg::sqrt_t  d_out
);
    logic [63:0]    bit_val;
    logic [63:0]    trial;
    afd_pkg::sqrt_t d_next;
    afd_pkg::sqrt_t d_reg;

    always_comb begin
        bit_val = 64'(1) << (6'd62 - {step, 1'b0});
        trial   = d_in.res + bit_val;
        if (d_in.n >= trial) begin
            d_next.n   = d_in.n - trial;
            d_next.res = (d_in.res >> 1) + bit_val;
        end else begin
            d_next.n   = d_in.n;
            d_next.res = d_in.res >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;
endmodule

FILE: sv/afd_div_cell.sv
// One quotient bit step of the restoring divider chain.
module afd_div_cell (
    input  logic           aclk,
    input  logic           en,
    input  logic           nbit,
    input  afd_pkg::div_t  d_in,
    output afd_pkg::div_t  d_out
);
    logic [32:0]   rs;
    afd_pkg::div_t d_next;
    afd_pkg::div_t d_reg;

    always_comb begin
        rs       = {d_in.r, nbit};
        d_next.d = d_in.d;
        if (rs >= {1'b0, d_in.d}) begin
            d_next.r = 32'(rs - {1'b0, d_in.d});
            d_next.q = {d_in.q[afd_pkg::QM_W-2:0], 1'b1};
        end else begin
            d_next.r = rs[31:0];
            d_next.q = {d_in.q[afd_pkg::QM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;
endmodule

FILE: sv/afd_cordic_cell.sv
// One vectoring stage of the CORDIC chain.
module afd_cordic_cell (
    input  logic              aclk,
    input  logic              en,
    input  logic [4:0]        step,
    input  afd_pkg::cordic_t  d_in,
    output afd_pkg::cordic_t  d_out
);
    logic signed [afd_pkg::VW-1:0] dx;
    logic signed [afd_pkg::VW-1:0] dy;
    logic signed [afd_pkg::ZW-1:0] at;
    afd_pkg::cordic_t              d_next;
    afd_pkg::cordic_t              d_reg;

    always_comb begin
        dx = d_in.y >>> step;
        dy = d_in.x >>> step;
        at = afd_pkg::ZW'(afd_pkg::atan_q30(step));
        if (d_in.y > 0) begin
            d_next.x = d_in.x + dx;
            d_next.y = d_in.y - dy;
            d_next.z = d_in.z + at;
        end else begin
            d_next.x = d_in.x - dx;
            d_next.y = d_in.y + dy;
            d_next.z = d_in.z - at;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;
endmodule

FILE: sv/affine2d_decompose_trs.sv
// Top level: pipelined 2D affine matrix decomposition into translation, scale and rotation.
// Throughput: one item per cycle while m_ does not stall; the cell chains (two row square roots, divider,
// sine square root, CORDIC) are one stage per cell and all advance together.
// A result held on m_ without m_ready freezes the pipeline and drops s_ready.
// Reset (aresetn low, synchronous) clears all stage valid bits and selects radians.
module affine2d_decompose_trs (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  afd_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output afd_pkg::out_t  m_data,
    input  logic           cfg_we,
    input  logic           cfg_wdata
);
    localparam int SQ  = afd_pkg::SQ_CELLS;
    localparam int DV  = afd_pkg::DIV_CELLS;
    localparam int CR  = afd_pkg::COR_CELLS;
    localparam int QW  = afd_pkg::QM_W;
    localparam int VWL = afd_pkg::VW;

    logic                        en;
    logic                        deg_reg;
    logic [afd_pkg::ST_OUT:1]    valid_reg;
    afd_pkg::side_t              side_reg [1:afd_pkg::ST_ANG];
    afd_pkg::side_t              side1_next;
    logic [63:0]                 sqa_reg, sqb_reg, sqc_reg, sqd_reg;
    logic [63:0]                 sumx_reg, sumy_reg;
    afd_pkg::sqrt_t              sqx [0:SQ];
    afd_pkg::sqrt_t              sqy [0:SQ];
    afd_pkg::sqrt_t              sqs [0:SQ];
    afd_pkg::div_t               dv  [0:DV];
    afd_pkg::cordic_t            cr  [0:CR];
    logic [QW-1:0]               qm_next;
    logic [QW-1:0]               qm_reg;
    logic [2*QW-1:0]             qsq_reg;
    logic [31:0]                 sx_sat, sy_sat;
    logic [QW-1:0]               c_qm;
    logic [QW-1:0]               c_s;
    logic                        c_neg;
    logic [31:0]                 zc_next;
    logic [31:0]                 zc_reg;
    logic [63:0]                 prod_reg;
    logic [64:0]                 rot_wide;
    afd_pkg::out_t               out_next;
    afd_pkg::out_t               out_reg;
    logic [31:0]                 ma, mb, mc, md;

    assign en      = !valid_reg[afd_pkg::ST_OUT] || m_ready;
    assign s_ready = en;
    assign m_valid = valid_reg[afd_pkg::ST_OUT];
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deg_reg   <= 1'b0;
            valid_reg <= '0;
        end else begin
            if (cfg_we) begin
                deg_reg <= cfg_wdata;
            end
            if (en) begin
                valid_reg <= {valid_reg[afd_pkg::ST_OUT-1:1], s_valid};
            end
        end
    end

    // square the row entries, then sum
    always_comb begin
        ma = afd_pkg::mag32(s_data.m00);
        mb = afd_pkg::mag32(s_data.m01);
        mc = afd_pkg::mag32(s_data.m10);
        md = afd_pkg::mag32(s_data.m11);
        side1_next         = '0;
        side1_next.trans_x = s_data.m20;
        side1_next.trans_y = s_data.m21;
        side1_next.a_mag   = ma;
        side1_next.a_neg   = s_data.m00[31];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqa_reg     <= 64'(ma) * 64'(ma);
            sqb_reg     <= 64'(mb) * 64'(mb);
            sqc_reg     <= 64'(mc) * 64'(mc);
            sqd_reg     <= 64'(md) * 64'(md);
            side_reg[1] <= side1_next;
            sumx_reg    <= sqa_reg + sqb_reg;
            sumy_reg    <= sqc_reg + sqd_reg;
        end
    end

    assign sx_sat = (sqx[SQ].res > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sqx[SQ].res[31:0];
    assign sy_sat = (sqy[SQ].res > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sqy[SQ].res[31:0];

    for (genvar i = 2; i <= afd_pkg::ST_ANG; i++) begin : g_side
        afd_pkg::side_t nxt;
        always_comb begin
            nxt = side_reg[i-1];
            if (i == afd_pkg::ST_SQ_END + 1) begin
                nxt.sx = sx_sat;
                nxt.sy = sy_sat;
            end
            if (i == afd_pkg::ST_QM + 1) begin
                nxt.qm = qm_reg;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[i] <= nxt;
            end
        end
    end

    // row length chains
    assign sqx[0] = '{n: sumx_reg, res: 64'd0};
    assign sqy[0] = '{n: sumy_reg, res: 64'd0};

    for (genvar i = 0; i < SQ; i++) begin : g_sq
        afd_sqrt_cell u_sx (
            .aclk(aclk), .en(en), .step(5'(i)), .d_in(sqx[i]), .d_out(sqx[i+1])
        );
        afd_sqrt_cell u_sy (
            .aclk(aclk), .en(en), .step(5'(i)), .d_in(sqy[i]), .d_out(sqy[i+1])
        );
    end

    // cosine quotient chain
    assign dv[0] = '{r: side_reg[afd_pkg::ST_SQ_END].a_mag >> 1, q: '0, d: sx_sat};

    for (genvar i = 0; i < DV; i++) begin : g_div
        afd_div_cell u_dv (
            .aclk (aclk),
            .en   (en),
            .nbit ((i == 0) ? side_reg[afd_pkg::ST_SQ_END].a_mag[0] : 1'b0),
            .d_in (dv[i]),
            .d_out(dv[i+1])
        );
    end

    assign qm_next = (dv[DV].q > afd_pkg::ONE_Q) ? afd_pkg::ONE_Q : dv[DV].q;

    always_ff @(posedge aclk) begin
        if (en) begin
            qm_reg  <= qm_next;
            qsq_reg <= (2*QW)'(qm_next) * (2*QW)'(qm_next);
        end
    end

    // sine chain
    assign sqs[0] = '{n: afd_pkg::ONE_SQ - 64'(qsq_reg), res: 64'd0};

    for (genvar i = 0; i < SQ; i++) begin : g_sin
        afd_sqrt_cell u_ss (
            .aclk(aclk), .en(en), .step(5'(i)), .d_in(sqs[i]), .d_out(sqs[i+1])
        );
    end

    // CORDIC vectoring chain
    always_comb begin
        c_qm  = side_reg[afd_pkg::ST_SIN_END].qm;
        c_s   = sqs[SQ].res[QW-1:0];
        c_neg = side_reg[afd_pkg::ST_SIN_END].a_neg && (c_qm != '0);
        if (c_neg) begin
            cr[0].x = VWL'(c_s) <<< afd_pkg::VEC_SHIFT;
            cr[0].y = VWL'(c_qm) <<< afd_pkg::VEC_SHIFT;
            cr[0].z = afd_pkg::PI_HALF;
        end else begin
            cr[0].x = VWL'(c_qm) <<< afd_pkg::VEC_SHIFT;
            cr[0].y = VWL'(c_s) <<< afd_pkg::VEC_SHIFT;
            cr[0].z = '0;
        end
    end

    for (genvar i = 0; i < CR; i++) begin : g_cor
        afd_cordic_cell u_cr (
            .aclk(aclk), .en(en), .step(5'(i)), .d_in(cr[i]), .d_out(cr[i+1])
        );
    end

    // clamp angle, scale to degrees when degree mode is set
    always_comb begin
        if (cr[CR].z < 0) begin
            zc_next = 32'd0;
        end else if (cr[CR].z > $signed(afd_pkg::PI_Z)) begin
            zc_next = afd_pkg::PI_Z[31:0];
        end else begin
            zc_next = cr[CR].z[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zc_reg   <= zc_next;
            prod_reg <= 64'(zc_next) * 64'(afd_pkg::DEG_K);
        end
    end

    always_comb begin
        if (deg_reg) begin
            rot_wide = (65'(prod_reg) + (65'(1) << (afd_pkg::DEG_SH - 1))) >> afd_pkg::DEG_SH;
        end else begin
            rot_wide = (65'(zc_reg) + (65'(1) << (afd_pkg::RAD_SH - 1))) >> afd_pkg::RAD_SH;
        end
        out_next.trans_x      = side_reg[afd_pkg::ST_ANG].trans_x;
        out_next.trans_y      = side_reg[afd_pkg::ST_ANG].trans_y;
        out_next.scale_x      = side_reg[afd_pkg::ST_ANG].sx;
        out_next.scale_y      = side_reg[afd_pkg::ST_ANG].sy;
        out_next.scale_x_zero = (side_reg[afd_pkg::ST_ANG].sx == 32'd0);
        if (out_next.scale_x_zero) begin
            out_next.rotation = 24'd0;
        end else if (rot_wide > afd_pkg::ROT_MAX) begin
            out_next.rotation = 24'hFFFFFF;
        end else begin
            out_next.rotation = rot_wide[23:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end
endmodule

FILE: sv/afd_checker.sv
// Port-level checker for the affine decomposition top level, with its bind.
module afd_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input afd_pkg::out_t  m_data
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_zero_rot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.scale_x_zero |-> m_data.rotation == 24'd0)
        else $error("rotation not zero for zero scale");

    a_zero_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.scale_x == 32'd0) == m_data.scale_x_zero)
        else $error("zero scale flag mismatch");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |-> s_ready)
        else $error("input stalled with free output");
endmodule

bind affine2d_decompose_trs afd_checker u_afd_checker (.*);

FILE: bench/affine2d_decompose_trs_chk.sv
// Checker: watches both channels, predicts each TRS decomposition and compares.
`timescale 1ns / 1ps
module affine2d_decompose_trs_chk (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  afd_pkg::in_t  s_data,
    input  logic          m_valid,
    input  logic          m_ready,
    input  afd_pkg::out_t m_data,
    input  logic          cfg_we,
    input  logic          cfg_wdata,
    output int            fails,
    output int            pending
);
    localparam longint HALF_PI_Z = 64'sd1686629713;
    localparam longint FULL_PI_Z = 64'sd3373259426;
    localparam longint unsigned DEG_PER_RAD = 64'd3845054675;

    afd_pkg::out_t decomp_q[$];
    bit            use_degrees;

    longint arctan_tab[32] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 0};

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned row_len(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        longint unsigned ma, mb, r;
        ma = a[31] ? 64'(-64'(a)) : 64'(a);
        mb = b[31] ? 64'(-64'(b)) : 64'(b);
        r = int_sqrt(ma * ma + mb * mb);
        return r > 64'hFFFFFFFF ? 64'hFFFFFFFF : r;
    endfunction

    function automatic logic [23:0] arccos_angle(input logic signed [31:0] a,
                                                 input longint unsigned sx, input bit deg);
        longint unsigned one, qm, zu, res, ma;
        longint q, s, x, y, z, dx, dy;
        int sh;
        one = 64'd1 << afd_pkg::FRAC_BITS;
        ma = a[31] ? 64'(-64'(a)) : 64'(a);
        qm = (ma << afd_pkg::FRAC_BITS) / sx;
        if (qm > one) qm = one;
        q = a[31] ? -longint'(qm) : longint'(qm);
        s = longint'(int_sqrt(one * one - qm * qm));
        if (q < 0) begin
            x = s; y = -q; z = HALF_PI_Z;
        end else begin
            x = q; y = s; z = 0;
        end
        x = x <<< (40 - afd_pkg::FRAC_BITS);
        y = y <<< (40 - afd_pkg::FRAC_BITS);
        for (int i = 0; i < afd_pkg::CORDIC_STAGES; i++) begin
            dx = y >>> (i & 31);
            dy = x >>> (i & 31);
            if (y > 0) begin
                x += dx; y -= dy; z += arctan_tab[i & 31];
            end else begin
                x -= dx; y += dy; z -= arctan_tab[i & 31];
            end
        end
        if (z < 0) z = 0;
        if (z > FULL_PI_Z) z = FULL_PI_Z;
        zu = longint'(z);
        if (deg) begin
            sh = 56 - afd_pkg::FRAC_BITS;
            res = (zu * DEG_PER_RAD + (64'd1 << (sh - 1))) >> sh;
        end else begin
            sh = 30 - afd_pkg::FRAC_BITS;
            res = (zu + (64'd1 << (sh - 1))) >> sh;
        end
        return res > 64'hFFFFFF ? 24'hFFFFFF : res[23:0];
    endfunction

    function automatic afd_pkg::out_t decompose(input afd_pkg::in_t m, input bit deg);
        afd_pkg::out_t r;
        longint unsigned sx;
        sx = row_len(m.m00, m.m01);
        r.trans_x = m.m20;
        r.trans_y = m.m21;
        r.scale_x = sx[31:0];
        r.scale_y = 32'(row_len(m.m10, m.m11));
        r.scale_x_zero = (sx == 0);
        r.rotation = (sx == 0) ? 24'd0 : arccos_angle(m.m00, sx, deg);
        return r;
    endfunction

    assign pending = decomp_q.size();

    always @(posedge aclk) begin
        afd_pkg::out_t want;
        if (!aresetn) begin
            use_degrees <= 1'b0;
            fails <= 0;
            decomp_q.delete();
        end else begin
            if (cfg_we) use_degrees <= cfg_wdata;
            if (s_valid && s_ready) decomp_q.push_back(decompose(s_data, use_degrees));
            if (m_valid && m_ready) begin
                if (decomp_q.size() == 0) begin
                    $display("%0t: unexpected item %h", $time, m_data);
                    fails <= fails + 1;
                end else begin
                    want = decomp_q.pop_front();
                    if (want != m_data) begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, m_data);
                        fails <= fails + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: bench/affine2d_decompose_trs_tb.sv
// Testbench top: drives matrices and mode writes, and gives the verdict.
`timescale 1ns / 1ps
module affine2d_decompose_trs_tb;
    localparam int LATENCY = 104;
    localparam longint LIMIT = 400000;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    afd_pkg::in_t  s_data = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    afd_pkg::out_t m_data;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;
    int   fails;
    int   pending;
    longint cycles = 0;
    int   gap_left = 0;
    int   burst_left = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    affine2d_decompose_trs dut (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata));

    affine2d_decompose_trs_chk chk (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .fails(fails), .pending(pending));

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("affine2d_decompose_trs_tb NOT OK");
            $finish;
        end
    end

    // receiver stall pattern: phases of free flow, light stalls and heavy stalls
    always @(posedge aclk) begin
        if (cycles[9:8] == 2'd1) m_ready <= 1'b1;
        else if (cycles[9:8] == 2'd3) m_ready <= ($urandom_range(0, 3) == 0);
        else m_ready <= ($urandom_range(0, 2) != 0);
    end

    function automatic logic [31:0] rand_entry();
        unique case ($urandom_range(0, 7))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return 32'd0;
            3: return 32'($signed($urandom_range(0, 262144)) - 131072);
            4: return 32'($signed($urandom_range(0, 1024)) - 512);
            default: return $urandom;
        endcase
    endfunction

    function automatic afd_pkg::in_t rand_matrix();
        afd_pkg::in_t m;
        int unsigned ang;
        m.m00 = rand_entry();
        m.m01 = rand_entry();
        m.m10 = rand_entry();
        m.m11 = rand_entry();
        m.m20 = $urandom;
        m.m21 = $urandom;
        ang = $urandom_range(0, 9);
        if (ang == 0) m.m01 = 0;
        if (ang == 1) m.m00 = 0;
        if (ang == 2) begin
            m.m00 = 0;
            m.m01 = 0;
        end
        return m;
    endfunction

    task automatic send(input afd_pkg::in_t m);
        while (gap_left > 0) begin
            s_valid <= 1'b0;
            gap_left--;
            @(posedge aclk);
        end
        s_data <= m;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic set_mode(input bit deg);
        cfg_we <= 1'b1;
        cfg_wdata <= deg;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        afd_pkg::in_t m;
        logic [31:0] vals[6];
        vals = '{32'h80000000, 32'h7FFFFFFF, 32'h00010000, 32'hFFFF0000, 32'd0, 32'd1};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int p = 0; p < 4; p++) begin
            set_mode(p[0]);
            for (int i = 0; i < 6; i++) begin
                m.m00 = vals[i];
                m.m01 = vals[(i + p) % 6];
                m.m10 = vals[(i + 1) % 6];
                m.m11 = vals[(i + 3) % 6];
                m.m20 = vals[(i + 2) % 6];
                m.m21 = ~vals[i];
                send(m);
            end
            m = '0;
            m.m00 = p[0] ? 32'hFFFF0000 : 32'h00010000;
            send(m);
            for (int k = 0; k < 110; k++) send(rand_matrix());
            drain();
        end
        if (fails == 0) $display("affine2d_decompose_trs_tb OK");
        else $display("affine2d_decompose_trs_tb NOT OK");
        $finish;
    end
endmodule

FILE: affine2d_decompose_trs.f
sv/afd_pkg.sv
sv/afd_sqrt_cell.sv
sv/afd_div_cell.sv
sv/afd_cordic_cell.sv
sv/affine2d_decompose_trs.sv
sv/afd_checker.sv
bench/affine2d_decompose_trs_chk.sv
bench/affine2d_decompose_trs_tb.sv
